// ----- rtl/core/ohm_pkg.sv -----
// Shared types and constants for the ordered hash map unit.
// No dependencies.
package ohm_pkg;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam logic [27:0] HASH_MUL = 28'h45d9f3b;

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_DEL  = 2'd2,
    OP_WALK = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_READONLY  = 3'd2,
    STS_STATIC    = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SL_EMPTY = 2'd0,
    SL_LIVE  = 2'd1,
    SL_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DISP,
    BK_PROBE_RD,
    BK_PROBE_CHK,
    BK_READ,
    BK_ACT,
    BK_LINK,
    BK_WALK_RD,
    BK_WALK_EMIT
  } back_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [63:0] value;
    logic [7:0]  flags;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key_out;
    logic [63:0] value_out;
    logic [7:0]  flags_out;
    logic [6:0]  entry_count;
    logic        last;
  } out_t;

  typedef struct packed {
    in_t           item;
    logic [IW-1:0] home;
  } job_t;

endpackage

// ----- rtl/core/ohm_front.sv -----
// Front end: accepts request beats and computes the home slot in two stages.
// Depends on ohm_pkg.
module ohm_front import ohm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic push_o,
  output job_t job_o,
  input  logic ready_i
);

  logic          s1_vld_q;
  in_t           s1_item_q;
  logic [31:0]   s1_mix_q;
  logic          s2_vld_q;
  in_t           s2_item_q;
  logic [IW+15:0] s2_prod_q;
  logic [59:0]   prod_full;
  logic          s1_go, s2_go, take;

  assign prod_full  = 60'(s1_mix_q) * 60'(HASH_MUL);
  assign s2_go      = s2_vld_q & ready_i;
  assign s1_go      = s1_vld_q & (~s2_vld_q | s2_go);
  assign in_stall_o = s1_vld_q & ~(~s2_vld_q | s2_go);
  assign take       = in_valid_i & ~in_stall_o;

  assign push_o        = s2_go;
  assign job_o.item    = s2_item_q;
  assign job_o.home    = s2_prod_q[IW-1:0] ^ s2_prod_q[IW+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (take) s1_vld_q <= 1'b1;
      else if (s1_go) s1_vld_q <= 1'b0;
      if (s1_go) s2_vld_q <= 1'b1;
      else if (s2_go) s2_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_item_q <= in_item_i;
      s1_mix_q  <= in_item_i.key ^ {16'b0, in_item_i.key[31:16]};
    end
    if (s1_go) begin
      s2_item_q <= s1_item_q;
      s2_prod_q <= prod_full[IW+15:0];
    end
  end

endmodule

// ----- rtl/core/ohm_queue.sv -----
// Two-entry queue between front end and back end.
// Depends on ohm_pkg.
module ohm_queue import ohm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ----- rtl/core/ohm_back.sv -----
// Back end: probes the slot table, applies get/set/delete, walks the order list.
// Depends on ohm_pkg; fed by ohm_queue.
module ohm_back import ohm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic read_only_i,
  input  logic q_valid_i,
  input  job_t q_job_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  logic [31:0]   key_mem [SLOTS];
  logic [63:0]   val_mem [SLOTS];
  logic [7:0]    fl_mem  [SLOTS];
  logic [IW-1:0] prv_mem [SLOTS];
  logic [IW-1:0] nxt_mem [SLOTS];
  logic [1:0]    slot_state_q [SLOTS];

  back_e state_q, state_d;
  job_t  cur_q;
  logic [IW-1:0] h_q, h_d, cnt_q, cnt_d, tomb_q, tomb_d, hit_q, hit_d, ins_q, ins_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, idx_q, idx_d, lnk_q, lnk_d;
  logic          tseen_q, tseen_d, found_q, found_d, insok_q, insok_d;
  logic [CW-1:0] live_q, live_d, wk_q, wk_d;
  logic          out_vld_q, out_vld_d;
  out_t          out_q, out_d;

  logic [31:0]   key_rd_q;
  logic [63:0]   val_rd_q;
  logic [7:0]    fl_rd_q;
  logic [1:0]    st_rd_q;
  logic [IW-1:0] prv_rd_q, nxt_rd_q, rd_addr;

  logic can_emit, match, is_empty, is_tomb, end_scan, probe_done, t_seen, wk_last;
  logic [IW-1:0] t_slot;
  logic [1:0] st_h;

  logic          we_slot, we_link, we_prv, we_nxt, set_live, set_tomb;
  logic [IW-1:0] wa_slot, wa_prv, wa_nxt, wd_prv, wd_nxt;

  assign can_emit    = ~out_vld_q | ~out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign st_h       = st_rd_q;
  assign match      = (st_h == SL_LIVE) && (key_rd_q == cur_q.item.key);
  assign is_empty   = (st_h != SL_LIVE) && (st_h != SL_TOMB);
  assign is_tomb    = (st_h == SL_TOMB);
  assign end_scan   = (cnt_q == IW'(SLOTS - 1));
  assign probe_done = match | is_empty | end_scan;
  assign t_seen     = tseen_q | is_tomb;
  assign t_slot     = tseen_q ? tomb_q : h_q;
  assign wk_last    = ((wk_q + CW'(1)) == live_q);

  always_comb begin
    case (state_q)
      BK_PROBE_RD:  rd_addr = h_q;
      BK_READ:      rd_addr = hit_q;
      BK_ACT:       rd_addr = hit_q;
      BK_WALK_RD:   rd_addr = idx_q;
      BK_WALK_EMIT: rd_addr = idx_q;
      default:      rd_addr = h_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:      if (q_valid_i) state_d = BK_DISP;
      BK_DISP: begin
        if (cur_q.item.operation == OP_WALK) begin
          if (live_q != '0) state_d = BK_WALK_RD;
          else if (can_emit) state_d = BK_IDLE;
        end else if (cur_q.item.operation != OP_GET && read_only_i) begin
          if (can_emit) state_d = BK_IDLE;
        end else begin
          state_d = BK_PROBE_RD;
        end
      end
      BK_PROBE_RD:  state_d = BK_PROBE_CHK;
      BK_PROBE_CHK: state_d = probe_done ? BK_READ : BK_PROBE_RD;
      BK_READ:      state_d = BK_ACT;
      BK_ACT: begin
        if (can_emit) begin
          if (cur_q.item.operation == OP_SET && !found_q && insok_q && live_q != '0)
            state_d = BK_LINK;
          else
            state_d = BK_IDLE;
        end
      end
      BK_LINK:      state_d = BK_IDLE;
      BK_WALK_RD:   state_d = BK_WALK_EMIT;
      BK_WALK_EMIT: if (can_emit) state_d = wk_last ? BK_IDLE : BK_WALK_RD;
      default:      state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    h_d = h_q; cnt_d = cnt_q; tomb_d = tomb_q; tseen_d = tseen_q;
    hit_d = hit_q; ins_d = ins_q; found_d = found_q; insok_d = insok_q;
    head_d = head_q; tail_d = tail_q; idx_d = idx_q; lnk_d = lnk_q;
    live_d = live_q; wk_d = wk_q;
    out_vld_d = out_vld_q & out_stall_i;
    out_d = out_q;
    we_slot = 1'b0; we_link = 1'b0; we_prv = 1'b0; we_nxt = 1'b0;
    set_live = 1'b0; set_tomb = 1'b0;
    wa_slot = ins_q; wa_prv = ins_q; wa_nxt = ins_q; wd_prv = ins_q; wd_nxt = ins_q;

    out_d.status      = STS_OK;
    out_d.key_out     = cur_q.item.key;
    out_d.value_out   = '0;
    out_d.flags_out   = '0;
    out_d.entry_count = 7'(live_q);
    out_d.last        = 1'b1;
    if (!can_emit || (state_q != BK_DISP && state_q != BK_ACT
        && state_q != BK_WALK_EMIT)) out_d = out_q;

    case (state_q)
      BK_IDLE: begin
        q_pop_o = q_valid_i;
      end
      BK_DISP: begin
        h_d = cur_q.home; cnt_d = '0; tseen_d = 1'b0; tomb_d = '0;
        idx_d = head_q; wk_d = '0;
        if (cur_q.item.operation == OP_WALK) begin
          if (live_q == '0 && can_emit) begin
            out_vld_d    = 1'b1;
            out_d.status = STS_NOT_FOUND;
          end
        end else if (cur_q.item.operation != OP_GET && read_only_i && can_emit) begin
          out_vld_d    = 1'b1;
          out_d.status = STS_READONLY;
        end
      end
      BK_PROBE_CHK: begin
        tseen_d = t_seen;
        tomb_d  = t_slot;
        found_d = match;
        hit_d   = h_q;
        ins_d   = match ? h_q : t_slot;
        insok_d = match | is_empty | t_seen;
        h_d     = h_q + IW'(1);
        cnt_d   = cnt_q + IW'(1);
      end
      BK_ACT: begin
        if (can_emit) begin
          out_vld_d = 1'b1;
          case (cur_q.item.operation)
            OP_GET: begin
              if (found_q) begin
                out_d.value_out = val_rd_q;
                out_d.flags_out = fl_rd_q;
              end else begin
                out_d.status = STS_NOT_FOUND;
              end
            end
            OP_SET: begin
              if (found_q) begin
                out_d.flags_out = fl_rd_q;
                if (fl_rd_q[0]) begin
                  out_d.status = STS_STATIC;
                end else begin
                  we_slot = 1'b1;
                  wa_slot = hit_q;
                end
              end else if (!insok_q) begin
                out_d.status = STS_FULL;
              end else begin
                we_slot  = 1'b1;
                wa_slot  = ins_q;
                set_live = 1'b1;
                we_link  = 1'b1;
                we_prv = 1'b1; wa_prv = ins_q; wd_prv = tail_q;
                we_nxt = 1'b1; wa_nxt = ins_q; wd_nxt = ins_q;
                if (live_q == '0) head_d = ins_q;
                lnk_d  = tail_q;
                tail_d = ins_q;
                live_d = live_q + CW'(1);
                out_d.entry_count = 7'(live_q + CW'(1));
              end
            end
            OP_DEL: begin
              if (!found_q) begin
                out_d.status = STS_NOT_FOUND;
              end else begin
                out_d.flags_out = fl_rd_q;
                if (fl_rd_q[0]) begin
                  out_d.status = STS_STATIC;
                end else begin
                  set_tomb = 1'b1;
                  if (hit_q == head_q) head_d = nxt_rd_q;
                  else begin
                    we_nxt = 1'b1; wa_nxt = prv_rd_q; wd_nxt = nxt_rd_q;
                  end
                  if (hit_q == tail_q) tail_d = prv_rd_q;
                  else begin
                    we_prv = 1'b1; wa_prv = nxt_rd_q; wd_prv = prv_rd_q;
                  end
                  live_d = live_q - CW'(1);
                  out_d.entry_count = 7'(live_q - CW'(1));
                end
              end
            end
            default: out_d.status = STS_NOT_FOUND;
          endcase
        end
      end
      BK_LINK: begin
        we_nxt = 1'b1; wa_nxt = lnk_q; wd_nxt = ins_q;
      end
      BK_WALK_EMIT: begin
        if (can_emit) begin
          out_vld_d       = 1'b1;
          out_d.key_out   = key_rd_q;
          out_d.value_out = val_rd_q;
          out_d.flags_out = fl_rd_q;
          out_d.last      = wk_last;
          idx_d = nxt_rd_q;
          wk_d  = wk_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      live_q    <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_state_q[i] <= SL_EMPTY;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      live_q    <= live_d;
      out_vld_q <= out_vld_d;
      if (set_live) slot_state_q[ins_q] <= SL_LIVE;
      if (set_tomb) slot_state_q[hit_q] <= SL_TOMB;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_job_i;
    h_q <= h_d; cnt_q <= cnt_d; tomb_q <= tomb_d; tseen_q <= tseen_d;
    hit_q <= hit_d; ins_q <= ins_d; found_q <= found_d; insok_q <= insok_d;
    idx_q <= idx_d; lnk_q <= lnk_d; wk_q <= wk_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
    fl_rd_q  <= fl_mem[rd_addr];
    prv_rd_q <= prv_mem[rd_addr];
    nxt_rd_q <= nxt_mem[rd_addr];
    st_rd_q  <= slot_state_q[rd_addr];
    if (we_slot) begin
      val_mem[wa_slot] <= cur_q.item.value;
      fl_mem[wa_slot]  <= cur_q.item.flags;
    end
    if (we_link) key_mem[ins_q] <= cur_q.item.key;
    if (we_prv) prv_mem[wa_prv] <= wd_prv;
    if (we_nxt) nxt_mem[wa_nxt] <= wd_nxt;
  end

endmodule

// ----- rtl/core/ordered_hash_map_unit.sv -----
// Ordered hash map unit: front end hashes, queue decouples, back end probes.
// A request passes the front-end hash registers and the queue; the back end then probes slot by slot.
// A walk reports each live entry in list order; an insert into a non-empty list adds a link step.
// The back end holds one item at a time and pops the next only when back in idle; a refused
// set or delete and an empty walk are answered straight from dispatch, without a probe.
// Reset clears slot states, list head/tail, live count, read_only and all valids.
module ordered_hash_map_unit import ohm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  logic read_only_q;
  logic push, ready, pop, q_valid;
  job_t job_f, job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) read_only_q <= 1'b0;
    else if (cfg_we_i) read_only_q <= cfg_wdata_i;
  end

  ohm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .push_o(push), .job_o(job_f), .ready_i(ready)
  );

  ohm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_f), .ready_o(ready),
    .pop_i(pop), .valid_o(q_valid), .job_o(job_q)
  );

  ohm_back u_back (
    .clk_i, .rst_ni, .read_only_i(read_only_q),
    .q_valid_i(q_valid), .q_job_i(job_q), .q_pop_o(pop),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

// ----- tb/tb_ordered_hash_map_unit.sv -----
// Self-checking testbench for ordered_hash_map_unit: random and directed map operations,
// checked beat by beat against a built-in predictor of the table and its order list.
// Depends on ohm_pkg and ordered_hash_map_unit.
`timescale 1ns / 100ps

module tb_ordered_hash_map_unit;
  import ohm_pkg::*;

  localparam int unsigned DRAIN_WAIT = 300;
  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned HOLD_LEN   = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_item_o;

  ordered_hash_map_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // map predictor state
  logic [31:0]   tbl_key   [SLOTS];
  slot_e         tbl_state [SLOTS];
  logic [63:0]   tbl_value [SLOTS];
  logic [7:0]    tbl_flags [SLOTS];
  logic [IW-1:0] lnk_prev  [SLOTS];
  logic [IW-1:0] lnk_next  [SLOTS];
  logic [IW-1:0] lnk_head;
  logic [IW-1:0] lnk_tail;
  int unsigned   n_live;
  logic          ro_mode;

  in_t         pend_items[$];
  out_t        exp_beats[$];
  logic [31:0] key_pool[$];
  int unsigned n_fail;
  int unsigned n_beats;
  int unsigned idle_cycles;

  function automatic logic [IW-1:0] home_of(logic [31:0] k);
    logic [63:0] p;
    p = {32'd0, k};
    p = p ^ (p >> 16);
    p = p * 64'(HASH_MUL);
    p = p ^ (p >> 16);
    return p[IW-1:0];
  endfunction

  function automatic out_t beat(status_e s, logic [31:0] k, logic [63:0] v, logic [7:0] f,
                                logic l);
    out_t o;
    o.status      = s;
    o.key_out     = k;
    o.value_out   = v;
    o.flags_out   = f;
    o.entry_count = 7'(n_live);
    o.last        = l;
    return o;
  endfunction

  task automatic predict_beats(in_t it);
    logic [IW-1:0] h, hit, ins, tomb, idx, p, n;
    logic          found, ins_ok, tomb_seen, done;
    logic [7:0]    old;
    if (op_e'(it.operation) == OP_WALK) begin
      if (n_live == 0) begin
        exp_beats.push_back(beat(STS_NOT_FOUND, it.key, '0, '0, 1'b1));
      end else begin
        idx = lnk_head;
        for (int k = 0; k < n_live; k++) begin
          exp_beats.push_back(beat(STS_OK, tbl_key[idx], tbl_value[idx], tbl_flags[idx],
                                   k + 1 == n_live));
          idx = lnk_next[idx];
        end
      end
      return;
    end
    if (op_e'(it.operation) != OP_GET && ro_mode) begin
      exp_beats.push_back(beat(STS_READONLY, it.key, '0, '0, 1'b1));
      return;
    end
    h = home_of(it.key);
    found = 0; ins_ok = 0; tomb_seen = 0; done = 0; tomb = '0; hit = '0; ins = '0;
    for (int i = 0; i < SLOTS && !done; i++) begin
      if (tbl_state[h] == SL_LIVE && tbl_key[h] == it.key) begin
        found = 1; hit = h; ins = h; ins_ok = 1; done = 1;
      end else if (tbl_state[h] == SL_TOMB) begin
        if (!tomb_seen) begin
          tomb_seen = 1;
          tomb = h;
        end
      end else if (tbl_state[h] != SL_LIVE) begin
        ins = tomb_seen ? tomb : h; ins_ok = 1; done = 1;
      end
      h = h + 1'b1;
    end
    if (!done) begin
      ins = tomb;
      ins_ok = tomb_seen;
    end
    case (op_e'(it.operation))
      OP_GET: begin
        if (found) exp_beats.push_back(beat(STS_OK, it.key, tbl_value[hit], tbl_flags[hit],
                                            1'b1));
        else exp_beats.push_back(beat(STS_NOT_FOUND, it.key, '0, '0, 1'b1));
      end
      OP_SET: begin
        if (found) begin
          old = tbl_flags[hit];
          if (old[0]) begin
            exp_beats.push_back(beat(STS_STATIC, it.key, '0, old, 1'b1));
          end else begin
            tbl_value[hit] = it.value;
            tbl_flags[hit] = it.flags;
            exp_beats.push_back(beat(STS_OK, it.key, '0, old, 1'b1));
          end
        end else if (!ins_ok) begin
          exp_beats.push_back(beat(STS_FULL, it.key, '0, '0, 1'b1));
        end else begin
          tbl_state[ins] = SL_LIVE;
          tbl_key[ins]   = it.key;
          tbl_value[ins] = it.value;
          tbl_flags[ins] = it.flags;
          lnk_prev[ins]  = lnk_tail;
          lnk_next[ins]  = ins;
          if (n_live == 0) lnk_head = ins;
          else lnk_next[lnk_tail] = ins;
          lnk_tail = ins;
          n_live++;
          exp_beats.push_back(beat(STS_OK, it.key, '0, '0, 1'b1));
        end
      end
      default: begin
        if (!found) begin
          exp_beats.push_back(beat(STS_NOT_FOUND, it.key, '0, '0, 1'b1));
        end else begin
          old = tbl_flags[hit];
          if (old[0]) begin
            exp_beats.push_back(beat(STS_STATIC, it.key, '0, old, 1'b1));
          end else begin
            p = lnk_prev[hit];
            n = lnk_next[hit];
            if (hit == lnk_head) lnk_head = n;
            else lnk_next[p] = n;
            if (hit == lnk_tail) lnk_tail = p;
            else lnk_prev[n] = p;
            tbl_state[hit] = SL_TOMB;
            tbl_value[hit] = '0;
            tbl_flags[hit] = '0;
            if (n_live > 0) n_live--;
            exp_beats.push_back(beat(STS_OK, it.key, '0, old, 1'b1));
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      n_fail++;
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  int unsigned gap_cnt;
  int unsigned drv_draw;
  logic        idle_on;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      gap_cnt    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_beats(in_item_i);
        drv_draw = idle_on ? $urandom_range(0, 17) : 0;
        if (drv_draw > 0 || pend_items.size() == 0) begin
          in_valid_i <= 1'b0;
          gap_cnt    <= drv_draw;
        end else begin
          in_item_i <= pend_items.pop_front();
        end
      end else if (!in_valid_i) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pend_items.size() > 0) begin
          in_item_i  <= pend_items.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // monitor
  int unsigned stall_cnt;
  int unsigned hold_cnt;
  logic        hold_done;
  int unsigned mon_draw;
  out_t        want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt   <= 0;
      hold_cnt    <= 0;
      hold_done   <= 1'b0;
    end else begin
      mon_draw = (stall_cnt > 0) ? stall_cnt - 1 : 0;
      if (out_valid_o && !out_stall_i) begin
        n_beats++;
        if (exp_beats.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %h", $time, out_item_o);
          n_fail++;
        end else begin
          want = exp_beats.pop_front();
          check_field("status", 64'(want.status), 64'(out_item_o.status));
          check_field("key_out", 64'(want.key_out), 64'(out_item_o.key_out));
          check_field("value_out", want.value_out, out_item_o.value_out);
          check_field("flags_out", 64'(want.flags_out), 64'(out_item_o.flags_out));
          check_field("entry_count", 64'(want.entry_count), 64'(out_item_o.entry_count));
          check_field("last", 64'(want.last), 64'(out_item_o.last));
        end
        mon_draw = idle_on ? $urandom_range(0, 17) : 0;
      end
      if (n_beats == 100 && !hold_done) begin
        hold_cnt    <= HOLD_LEN;
        hold_done   <= 1'b1;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_stall_i <= (hold_cnt > 1);
      end else begin
        out_stall_i <= (mon_draw > 0);
      end
      stall_cnt <= mon_draw;
    end
  end

  // watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic in_t mk(op_e op, logic [31:0] k, logic [63:0] v, logic [7:0] f);
    in_t it;
    it.operation = op;
    it.key       = k;
    it.value     = v;
    it.flags     = f;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] rand_flags();
    logic [7:0] f;
    f = 8'($urandom_range(0, 255));
    f[0] = ($urandom_range(0, 3) == 0);
    return f;
  endfunction

  function automatic in_t rand_item(int unsigned pool_n);
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, pool_n - 1)];
    if (r < 45) return mk(OP_SET, k, rand64(), rand_flags());
    if (r < 70) return mk(OP_GET, k, rand64(), 8'($urandom_range(0, 255)));
    if (r < 93) return mk(OP_DEL, k, rand64(), 8'($urandom_range(0, 255)));
    return mk(OP_WALK, $urandom(), rand64(), 8'($urandom_range(0, 255)));
  endfunction

  task automatic drain();
    do @(negedge clk_i);
    while (pend_items.size() != 0 || in_valid_i || exp_beats.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_ro(logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    ro_mode = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    n_fail      = 0;
    n_beats     = 0;
    idle_on     = 1'b0;
    n_live      = 0;
    ro_mode     = 1'b0;
    lnk_head    = '0;
    lnk_tail    = '0;
    foreach (tbl_state[i]) tbl_state[i] = SL_EMPTY;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_ro(1'b0);
    pend_items.push_back(mk(OP_GET, 32'h1234_5678, '0, '0));
    pend_items.push_back(mk(OP_WALK, 32'hffff_ffff, '1, '1));
    pend_items.push_back(mk(OP_DEL, 32'h1, '0, '0));
    pend_items.push_back(mk(OP_SET, 32'h0, 64'h0123_4567_89ab_cdef, 8'hfe));
    pend_items.push_back(mk(OP_SET, 32'hffff_ffff, '1, 8'hff));
    pend_items.push_back(mk(OP_SET, 32'h1, '0, 8'h00));
    pend_items.push_back(mk(OP_GET, 32'h0, '0, '0));
    pend_items.push_back(mk(OP_GET, 32'hffff_ffff, '0, '0));
    pend_items.push_back(mk(OP_SET, 32'hffff_ffff, 64'h5, 8'h00));
    pend_items.push_back(mk(OP_DEL, 32'hffff_ffff, '0, '0));
    pend_items.push_back(mk(OP_SET, 32'h1, 64'hdead_beef, 8'h80));
    pend_items.push_back(mk(OP_WALK, 32'h0, '0, '0));
    pend_items.push_back(mk(OP_DEL, 32'h1, '0, '0));
    pend_items.push_back(mk(OP_DEL, 32'h1, '0, '0));
    pend_items.push_back(mk(OP_GET, 32'h1, '0, '0));
    pend_items.push_back(mk(OP_SET, 32'h1, '1, 8'h7e));
    pend_items.push_back(mk(OP_DEL, 32'h0, '0, '0));
    pend_items.push_back(mk(OP_WALK, 32'h2, '0, '0));
    drain();
    write_ro(1'b1);
    pend_items.push_back(mk(OP_GET, 32'hffff_ffff, '0, '0));
    pend_items.push_back(mk(OP_SET, 32'h9, '1, 8'h00));
    pend_items.push_back(mk(OP_DEL, 32'h1, '0, '0));
    pend_items.push_back(mk(OP_WALK, 32'h3, '0, '0));
    drain();
    write_ro(1'b0);

    // fill the table to capacity, then mix operations over a wide key set
    idle_on = 1'b1;
    for (int i = 0; i < 96; i++) key_pool.push_back($urandom());
    for (int i = 0; i < 72; i++) pend_items.push_back(mk(OP_SET, key_pool[i], rand64(),
                                                          rand_flags()));
    for (int i = 0; i < 60; i++) begin
      if (i == 30) idle_on = 1'b0;
      pend_items.push_back(rand_item(96));
    end
    drain();
    idle_on = 1'b1;
    write_ro(1'b1);
    for (int i = 0; i < 40; i++) pend_items.push_back(rand_item(96));
    drain();
    write_ro(1'b0);
    for (int i = 0; i < 150; i++) begin
      idle_on = (i % 50) < 35;
      pend_items.push_back(rand_item(24));
    end
    drain();

    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
